@@ rtl/bsfr_pkg.sv @@
// Package for the byte-stuffed frame receiver.
// Holds shared widths, register indexes, reset values, result kinds and structs.
// No dependencies.
package bsfr_pkg;

  localparam int RING_DEPTH_DEF = 1024;

  localparam int BYTE_W  = 8;
  localparam int CRC_W   = 16;
  localparam int FLEN_W  = 10;
  localparam int CNT_W   = 32;
  localparam int KIND_W  = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;
  localparam int ODATA_W = 88;

  localparam int HDR_MIN_LEN = 4;
  localparam int HDR_OFFSET  = 6;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_DATA    = 2'd0;
  localparam kind_t KIND_GOOD    = 2'd1;
  localparam kind_t KIND_CRC_ERR = 2'd2;
  localparam kind_t KIND_LEN_ERR = 2'd3;

  typedef logic [CIDX_W-1:0] cidx_t;
  localparam cidx_t REG_FLAG     = 3'd0;
  localparam cidx_t REG_ESCAPE   = 3'd1;
  localparam cidx_t REG_FLAG_SUB = 3'd2;
  localparam cidx_t REG_ESC_SUB  = 3'd3;
  localparam cidx_t REG_CRC_POLY = 3'd4;
  localparam cidx_t REG_CRC_INIT = 3'd5;

  localparam logic [BYTE_W-1:0] FLAG_RST     = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RST   = 8'd125;
  localparam logic [BYTE_W-1:0] FLAG_SUB_RST = 8'd94;
  localparam logic [BYTE_W-1:0] ESC_SUB_RST  = 8'd93;
  localparam logic [CRC_W-1:0]  CRC_POLY_RST = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT_RST = 16'hFFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] flag_sub;
    logic [BYTE_W-1:0] escape_sub;
    logic [CRC_W-1:0]  crc_poly;
    logic [CRC_W-1:0]  crc_init;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [FLEN_W-1:0] frame_length;
    logic [CNT_W-1:0]  total_count;
    logic [CNT_W-1:0]  overrun_count;
  } result_t;

endpackage

@@ rtl/bsfr_crc_byte.sv @@
// Byte-wide CRC-16 update, MSB first, with a programmable polynomial.
// Purely combinational. Depends on bsfr_pkg.
module bsfr_crc_byte (
  input  logic [bsfr_pkg::CRC_W-1:0]  crc_in,
  input  logic [bsfr_pkg::BYTE_W-1:0] data_in,
  input  logic [bsfr_pkg::CRC_W-1:0]  poly,
  output logic [bsfr_pkg::CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [bsfr_pkg::CRC_W-1:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < bsfr_pkg::BYTE_W; i++) begin
      if (c[bsfr_pkg::CRC_W-1]) begin
        c = {c[bsfr_pkg::CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[bsfr_pkg::CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

@@ rtl/bsfr_deframe.sv @@
// Deframing state and per-word decision logic: unescaping, CRC, length and counters.
// Depends on bsfr_pkg and bsfr_crc_byte.
module bsfr_deframe #(
  parameter int RING_DEPTH = bsfr_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [bsfr_pkg::BYTE_W-1:0] rx_byte,
  input  bsfr_pkg::cfg_t              cfg,
  output logic                        res_valid,
  output bsfr_pkg::result_t           res
);

  localparam int LEN_W = $clog2(RING_DEPTH);
  localparam int CMP_W = 17;

  logic                        esc_r, esc_nxt;
  logic [bsfr_pkg::CRC_W-1:0]  crc_r, crc_nxt, crc_fold;
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic [bsfr_pkg::BYTE_W-1:0] hdr_hi_r, hdr_hi_nxt, hdr_lo_r, hdr_lo_nxt;
  logic [bsfr_pkg::CNT_W-1:0]  total_r, total_nxt, drop_r, drop_nxt;
  logic [bsfr_pkg::BYTE_W-1:0] byte_val;
  logic [CMP_W-1:0]            len_ext, len_minus;
  bsfr_pkg::kind_t             frame_kind;

  bsfr_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (byte_val),
    .poly    (cfg.crc_poly),
    .crc_out (crc_fold)
  );

  assign len_ext   = CMP_W'(len_r);
  assign len_minus = len_ext - CMP_W'(bsfr_pkg::HDR_OFFSET);

  always_comb begin
    if (esc_r) begin
      if (rx_byte == cfg.flag_sub) begin
        byte_val = cfg.flag_byte;
      end else if (rx_byte == cfg.escape_sub) begin
        byte_val = cfg.escape_byte;
      end else begin
        byte_val = '0;
      end
    end else begin
      byte_val = rx_byte;
    end
  end

  always_comb begin
    frame_kind = bsfr_pkg::KIND_GOOD;
    if (crc_r != '0) begin
      frame_kind = bsfr_pkg::KIND_CRC_ERR;
    end else if (len_ext > CMP_W'(bsfr_pkg::HDR_MIN_LEN)) begin
      if (len_ext < CMP_W'(bsfr_pkg::HDR_OFFSET) ||
          len_minus != CMP_W'({hdr_hi_r, hdr_lo_r})) begin
        frame_kind = bsfr_pkg::KIND_LEN_ERR;
      end
    end
  end

  always_comb begin
    esc_nxt    = esc_r;
    crc_nxt    = crc_r;
    len_nxt    = len_r;
    hdr_hi_nxt = hdr_hi_r;
    hdr_lo_nxt = hdr_lo_r;
    total_nxt  = total_r;
    drop_nxt   = drop_r;
    res_valid  = 1'b0;
    res        = '0;
    if (rx_byte == cfg.flag_byte) begin
      crc_nxt = cfg.crc_init;
      if (len_r != '0) begin
        res_valid        = 1'b1;
        res.kind         = frame_kind;
        res.frame_length = bsfr_pkg::FLEN_W'(len_r);
        len_nxt          = '0;
      end
    end else if (!esc_r && rx_byte == cfg.escape_byte) begin
      esc_nxt = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      crc_nxt = crc_fold;
      if (len_r < LEN_W'(RING_DEPTH - 1)) begin
        if (len_ext == CMP_W'(2)) begin
          hdr_hi_nxt = byte_val;
        end else if (len_ext == CMP_W'(3)) begin
          hdr_lo_nxt = byte_val;
        end
        len_nxt          = len_r + LEN_W'(1);
        total_nxt        = total_r + 1'b1;
        res_valid        = 1'b1;
        res.kind         = bsfr_pkg::KIND_DATA;
        res.data_byte    = byte_val;
        res.frame_length = bsfr_pkg::FLEN_W'(len_nxt);
      end else begin
        drop_nxt = drop_r + 1'b1;
      end
    end
    res.total_count   = total_nxt;
    res.overrun_count = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 1'b0;
      crc_r    <= bsfr_pkg::CRC_INIT_RST;
      len_r    <= '0;
      hdr_hi_r <= '0;
      hdr_lo_r <= '0;
      total_r  <= '0;
      drop_r   <= '0;
    end else if (step) begin
      esc_r    <= esc_nxt;
      crc_r    <= crc_nxt;
      len_r    <= len_nxt;
      hdr_hi_r <= hdr_hi_nxt;
      hdr_lo_r <= hdr_lo_nxt;
      total_r  <= total_nxt;
      drop_r   <= drop_nxt;
    end
  end

endmodule

@@ rtl/byte_stuffed_frame_receiver_crc_check_core.sv @@
// Byte-stuffed frame receiver with CRC-16 check: input register, deframer, result register.
// One word per cycle sustained while the output is not stalled; each word passes the input
// register and the deframer into the result register. While a result waits, one more word
// is held and then the input stalls. Escape bytes, dropped bytes and flags that close an
// empty frame give no result. Synchronous active-low reset loads register defaults and
// clears all control state. Depends on bsfr_pkg and bsfr_deframe.
module byte_stuffed_frame_receiver_crc_check_core #(
  parameter int RING_DEPTH = bsfr_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bsfr_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bsfr_pkg::ODATA_W-1:0]  out_tdata,  // [7:0] data_byte, [17:8] frame_length,
                                                    // [49:18] total_count,
                                                    // [81:50] overrun_count, [87:82] zero
  output logic [bsfr_pkg::KIND_W-1:0]   out_tuser,  // [1:0] kind
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsfr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bsfr_pkg::CDATA_W-1:0]  cfg_data
);

  bsfr_pkg::cfg_t              cfg_r;
  logic                        in_vld_r;
  logic [bsfr_pkg::BYTE_W-1:0] in_byte_r;
  logic                        step;
  logic                        res_valid;
  bsfr_pkg::result_t           res;
  logic                        out_vld_r;
  bsfr_pkg::result_t           out_res_r;

  assign cfg_ready = 1'b1;
  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte   <= bsfr_pkg::FLAG_RST;
      cfg_r.escape_byte <= bsfr_pkg::ESCAPE_RST;
      cfg_r.flag_sub    <= bsfr_pkg::FLAG_SUB_RST;
      cfg_r.escape_sub  <= bsfr_pkg::ESC_SUB_RST;
      cfg_r.crc_poly    <= bsfr_pkg::CRC_POLY_RST;
      cfg_r.crc_init    <= bsfr_pkg::CRC_INIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsfr_pkg::REG_FLAG:     cfg_r.flag_byte   <= cfg_data[bsfr_pkg::BYTE_W-1:0];
        bsfr_pkg::REG_ESCAPE:   cfg_r.escape_byte <= cfg_data[bsfr_pkg::BYTE_W-1:0];
        bsfr_pkg::REG_FLAG_SUB: cfg_r.flag_sub    <= cfg_data[bsfr_pkg::BYTE_W-1:0];
        bsfr_pkg::REG_ESC_SUB:  cfg_r.escape_sub  <= cfg_data[bsfr_pkg::BYTE_W-1:0];
        bsfr_pkg::REG_CRC_POLY: cfg_r.crc_poly    <= cfg_data;
        bsfr_pkg::REG_CRC_INIT: cfg_r.crc_init    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  bsfr_deframe #(
    .RING_DEPTH (RING_DEPTH)
  ) u_deframe (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {6'b0, out_res_r.overrun_count, out_res_r.total_count,
                       out_res_r.frame_length, out_res_r.data_byte};

endmodule

@@ tb/byte_stuffed_frame_receiver_crc_check_core_test.sv @@
// Self-checking bench for the byte-stuffed frame receiver core.
// Feeds stuffed CRC-16 frames and line noise, and checks every result word.
// Depends on bsfr_pkg and the core RTL.
`timescale 1ns / 100ps

module byte_stuffed_frame_receiver_crc_check_core_test;

  typedef enum {DMG_NONE, DMG_FLIP, DMG_TRUNC} damage_t;

  localparam int              FRAME_CAP      = bsfr_pkg::RING_DEPTH_DEF - 1;
  localparam int              DRAIN_CYCLES   = 8;
  localparam int              RX_HOLD_CYCLES = 400;
  localparam int              PHASE_WORDS    = 40;
  localparam int              TIMEOUT_NS     = 5_000_000;
  localparam int              MAX_PRINTS     = 40;
  localparam bsfr_pkg::cidx_t REG_UNMAPPED_6 = 3'd6;
  localparam bsfr_pkg::cidx_t REG_UNMAPPED_7 = 3'd7;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [bsfr_pkg::BYTE_W-1:0]   in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [bsfr_pkg::ODATA_W-1:0]  out_tdata;
  logic [bsfr_pkg::KIND_W-1:0]   out_tuser;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  bsfr_pkg::cidx_t               cfg_index  = '0;
  logic [bsfr_pkg::CDATA_W-1:0]  cfg_data   = '0;

  byte_stuffed_frame_receiver_crc_check_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  bsfr_pkg::cfg_t              line_cfg = '{bsfr_pkg::FLAG_RST, bsfr_pkg::ESCAPE_RST,
                                            bsfr_pkg::FLAG_SUB_RST, bsfr_pkg::ESC_SUB_RST,
                                            bsfr_pkg::CRC_POLY_RST, bsfr_pkg::CRC_INIT_RST};
  logic                        esc_armed    = 1'b0;
  logic [bsfr_pkg::CRC_W-1:0]  frame_crc    = bsfr_pkg::CRC_INIT_RST;
  int                          frame_len    = 0;
  logic [bsfr_pkg::BYTE_W-1:0] hdr_hi       = '0;
  logic [bsfr_pkg::BYTE_W-1:0] hdr_lo       = '0;
  logic [bsfr_pkg::CNT_W-1:0]  stored_cnt   = '0;
  logic [bsfr_pkg::CNT_W-1:0]  dropped_cnt  = '0;

  logic [bsfr_pkg::BYTE_W-1:0] line_q[$];
  bsfr_pkg::result_t           deframed_q[$];
  int                          words_queued = 0;
  int                          mismatch_cnt = 0;
  int                          tx_idle_pct  = 0;
  int                          rx_stall_pct = 0;
  int                          rx_hold_left = 0;
  bit                          rx_hold_go   = 1'b0;

  function automatic logic [bsfr_pkg::CRC_W-1:0] crc_step(
      input logic [bsfr_pkg::CRC_W-1:0] crc,
      input logic [bsfr_pkg::BYTE_W-1:0] b,
      input logic [bsfr_pkg::CRC_W-1:0] poly);
    crc = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) crc = crc[15] ? ((crc << 1) ^ poly) : (crc << 1);
    return crc;
  endfunction

  function automatic void deframe_byte(input logic [bsfr_pkg::BYTE_W-1:0] rx);
    bsfr_pkg::result_t           r;
    logic [bsfr_pkg::BYTE_W-1:0] b;
    logic [15:0]                 hdr;
    b = rx;
    if (b == line_cfg.flag_byte) begin
      if (frame_len != 0) begin
        r.kind = bsfr_pkg::KIND_CRC_ERR;
        if (frame_crc == '0) begin
          r.kind = bsfr_pkg::KIND_GOOD;
          hdr = {hdr_hi, hdr_lo};
          if (frame_len > bsfr_pkg::HDR_MIN_LEN &&
              (frame_len < bsfr_pkg::HDR_OFFSET ||
               int'(hdr) != frame_len - bsfr_pkg::HDR_OFFSET)) begin
            r.kind = bsfr_pkg::KIND_LEN_ERR;
          end
        end
        r.data_byte     = '0;
        r.frame_length  = bsfr_pkg::FLEN_W'(frame_len);
        r.total_count   = stored_cnt;
        r.overrun_count = dropped_cnt;
        deframed_q.push_back(r);
        frame_len = 0;
      end
      frame_crc = line_cfg.crc_init;
      return;
    end
    if (esc_armed) begin
      if (b == line_cfg.flag_sub) b = line_cfg.flag_byte;
      else if (b == line_cfg.escape_sub) b = line_cfg.escape_byte;
      else b = '0;
      esc_armed = 1'b0;
    end else if (b == line_cfg.escape_byte) begin
      esc_armed = 1'b1;
      return;
    end
    frame_crc = crc_step(frame_crc, b, line_cfg.crc_poly);
    if (frame_len < FRAME_CAP) begin
      if (frame_len == 2) hdr_hi = b;
      else if (frame_len == 3) hdr_lo = b;
      frame_len++;
      stored_cnt++;
      r.kind          = bsfr_pkg::KIND_DATA;
      r.data_byte     = b;
      r.frame_length  = bsfr_pkg::FLEN_W'(frame_len);
      r.total_count   = stored_cnt;
      r.overrun_count = dropped_cnt;
      deframed_q.push_back(r);
    end else begin
      dropped_cnt++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  task automatic check_result();
    bsfr_pkg::result_t want;
    bsfr_pkg::result_t seen;
    seen.kind          = out_tuser;
    seen.data_byte     = out_tdata[7:0];
    seen.frame_length  = out_tdata[17:8];
    seen.total_count   = out_tdata[49:18];
    seen.overrun_count = out_tdata[81:50];
    if (deframed_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d", seen.kind));
      return;
    end
    want = deframed_q.pop_front();
    if (seen.kind != want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", seen.kind, want.kind));
    if (seen.data_byte != want.data_byte)
      report_mismatch($sformatf("data_byte %h, want %h", seen.data_byte, want.data_byte));
    if (seen.frame_length != want.frame_length)
      report_mismatch($sformatf("frame_length %0d, want %0d",
                                seen.frame_length, want.frame_length));
    if (seen.total_count != want.total_count)
      report_mismatch($sformatf("total_count %0d, want %0d",
                                seen.total_count, want.total_count));
    if (seen.overrun_count != want.overrun_count)
      report_mismatch($sformatf("overrun_count %0d, want %0d",
                                seen.overrun_count, want.overrun_count));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (line_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tdata  <= line_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      out_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_go) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end
  end

  function automatic void push_word(input logic [bsfr_pkg::BYTE_W-1:0] b);
    line_q.push_back(b);
    words_queued++;
  endfunction

  function automatic logic [bsfr_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0: return line_cfg.flag_byte;
      1: return line_cfg.escape_byte;
      2: return line_cfg.flag_sub;
      3: return line_cfg.escape_sub;
      default: return bsfr_pkg::BYTE_W'($urandom);
    endcase
  endfunction

  function automatic void push_frame(input int body_len, input bit hdr_ok,
                                     input damage_t damage, input bit lead_flag);
    logic [bsfr_pkg::BYTE_W-1:0] fr[$];
    logic [bsfr_pkg::CRC_W-1:0]  crc;
    logic [15:0]                 len_field;
    int                          pos;
    crc = line_cfg.crc_init;
    for (int i = 0; i < body_len; i++) fr.push_back(pick_byte());
    if (body_len >= bsfr_pkg::HDR_MIN_LEN) begin
      len_field = hdr_ok ? 16'(body_len + 2 - bsfr_pkg::HDR_OFFSET) : 16'($urandom);
      fr[2] = len_field[15:8];
      fr[3] = len_field[7:0];
    end
    foreach (fr[i]) crc = crc_step(crc, fr[i], line_cfg.crc_poly);
    fr.push_back(crc[15:8]);
    fr.push_back(crc[7:0]);
    if (damage == DMG_FLIP) begin
      pos = $urandom_range(fr.size() - 1);
      fr[pos] = fr[pos] ^ bsfr_pkg::BYTE_W'(1 << $urandom_range(7));
    end else if (damage == DMG_TRUNC) begin
      void'(fr.pop_back());
    end
    if (lead_flag) push_word(line_cfg.flag_byte);
    foreach (fr[i]) begin
      if (fr[i] == line_cfg.flag_byte) begin
        push_word(line_cfg.escape_byte);
        push_word(line_cfg.flag_sub);
      end else if (fr[i] == line_cfg.escape_byte) begin
        push_word(line_cfg.escape_byte);
        push_word(line_cfg.escape_sub);
      end else begin
        push_word(fr[i]);
      end
    end
    push_word(line_cfg.flag_byte);
  endfunction

  function automatic void make_traffic(input int budget);
    int start;
    int pick;
    int n;
    start = words_queued;
    while (words_queued - start < budget) begin
      pick = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
      if (pick < 70) begin
        push_frame(n, $urandom_range(99) < 85, DMG_NONE, $urandom_range(1));
      end else if (pick < 82) begin
        if ($urandom_range(1)) push_frame(n, 1'b1, DMG_FLIP, 1'b1);
        else push_frame(n, 1'b1, DMG_TRUNC, 1'b1);
      end else begin
        repeat (1 + $urandom_range(5)) push_word(pick_byte());
      end
    end
  endfunction

  task automatic write_reg(input bsfr_pkg::cidx_t idx,
                           input logic [bsfr_pkg::CDATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bsfr_pkg::REG_FLAG:     line_cfg.flag_byte   = val[7:0];
      bsfr_pkg::REG_ESCAPE:   line_cfg.escape_byte = val[7:0];
      bsfr_pkg::REG_FLAG_SUB: line_cfg.flag_sub    = val[7:0];
      bsfr_pkg::REG_ESC_SUB:  line_cfg.escape_sub  = val[7:0];
      bsfr_pkg::REG_CRC_POLY: line_cfg.crc_poly    = val;
      bsfr_pkg::REG_CRC_INIT: line_cfg.crc_init    = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] fl, input logic [7:0] es, input logic [7:0] fs,
                            input logic [7:0] ess, input logic [15:0] poly,
                            input logic [15:0] init);
    write_reg(bsfr_pkg::REG_FLAG, {8'h00, fl});
    write_reg(bsfr_pkg::REG_ESCAPE, {8'h00, es});
    write_reg(bsfr_pkg::REG_FLAG_SUB, {8'h00, fs});
    write_reg(bsfr_pkg::REG_ESC_SUB, {8'h00, ess});
    write_reg(bsfr_pkg::REG_CRC_POLY, poly);
    write_reg(bsfr_pkg::REG_CRC_INIT, init);
    @(negedge clk);
  endtask

  task automatic random_config(input bit same_subs);
    logic [7:0] v[4];
    do begin
      foreach (v[i]) v[i] = $urandom;
      if (same_subs) v[3] = v[2];
    end while (v[0] == v[1] || v[0] == v[2] || v[0] == v[3] || v[1] == v[2] ||
               v[1] == v[3] || (!same_subs && v[2] == v[3]));
    set_config(v[0], v[1], v[2], v[3], 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    while (line_q.size() != 0 || in_tvalid || deframed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values stay in use; the unmapped indexes must leave the setup alone.
    write_reg(REG_UNMAPPED_6, 16'($urandom));
    write_reg(REG_UNMAPPED_7, 16'($urandom));
    @(negedge clk);

    push_word(line_cfg.flag_byte);
    push_frame(1, 1'b1, DMG_NONE, 1'b0);
    push_frame(3, 1'b1, DMG_NONE, 1'b0);
    push_word(8'h00);
    push_word(8'hFF);
    push_word(line_cfg.escape_byte);
    push_word(line_cfg.flag_sub);
    push_word(line_cfg.escape_byte);
    push_word(line_cfg.escape_sub);
    push_word(line_cfg.escape_byte);
    push_word(8'h00);
    push_word(line_cfg.escape_byte);
    push_word(line_cfg.escape_byte);
    push_word(line_cfg.escape_byte);
    push_word(line_cfg.flag_byte);
    push_word(8'h11);
    push_word(line_cfg.flag_byte);
    wait_drained();

    // Full-rate phase with a long output stall so the input side backs up.
    random_config(1'b0);
    make_traffic(PHASE_WORDS);
    rx_hold_go = 1'b1;
    while (rx_hold_left == 0) @(negedge clk);
    rx_hold_go = 1'b0;
    wait_drained();

    tx_idle_pct = 58;
    set_config(8'h00, 8'hFF, 8'h01, 8'hFE, 16'hFFFF, 16'h0000);
    make_traffic(PHASE_WORDS);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 58;
    set_config(8'hFF, 8'h00, 8'hFE, 8'h01, 16'h0000, 16'hFFFF);
    make_traffic(PHASE_WORDS / 2);
    push_frame(FRAME_CAP + 1, 1'b1, DMG_NONE, 1'b1);
    make_traffic(PHASE_WORDS / 2);
    wait_drained();

    tx_idle_pct  = 10;
    rx_stall_pct = 10;
    random_config(1'b1);
    make_traffic(PHASE_WORDS);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ byte_stuffed_frame_receiver_crc_check_core.f @@
rtl/bsfr_pkg.sv
rtl/bsfr_crc_byte.sv
rtl/bsfr_deframe.sv
rtl/byte_stuffed_frame_receiver_crc_check_core.sv
tb/byte_stuffed_frame_receiver_crc_check_core_test.sv
